// ----- hw/rtl/b2da_pkg.sv -----
// Shared widths, types and character codes for the binary to decimal text converter.
`default_nettype none

package b2da_pkg;

  localparam int NUM_W    = 16;                 // binary input width
  localparam int HALF_W   = NUM_W / 2;          // binary bits handled per dabble stage
  localparam int DIGIT_W  = 4;                  // one BCD digit
  localparam int DIGITS   = 5;                  // 65535 has five decimal digits
  localparam int BCD_W    = DIGIT_W * DIGITS;
  localparam int CHAR_W   = 6;                  // characters are carried in six bits
  localparam int LEAD_W   = 3;                  // leading zero count, 0..DIGITS-1
  localparam int SHIFT_W  = LEAD_W + 2;         // lead count times four

  typedef logic [NUM_W-1:0]   num_t;
  typedef logic [HALF_W-1:0]  half_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [BCD_W-1:0]   bcd_t;
  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [LEAD_W-1:0]  lead_t;

  // ASCII codes as they appear in the six-bit character fields
  localparam char_t ASCII_ZERO  = 6'd48;
  localparam char_t ASCII_SPACE = 6'd32;

  // Double dabble correction: a digit of five or more gets three added before the shift
  localparam digit_t DABBLE_LIMIT = 4'd5;
  localparam digit_t DABBLE_ADD   = 4'd3;

  // Pipeline stage flow control, one per stage
  typedef struct packed {
    logic valid;
    logic enable;
  } stage_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/b2da_if.sv -----
// Valid/ready channel interfaces for the converter's input and result items.
`default_nettype none

interface b2da_in_if;
  logic                     valid;
  logic                     ready;
  logic [b2da_pkg::NUM_W-1:0] number_in;

  modport source (output valid, output number_in, input ready);
  modport sink   (input valid, input number_in, output ready);
endinterface

interface b2da_out_if;
  logic                        valid;
  logic                        ready;
  logic [b2da_pkg::CHAR_W-1:0] char_pos0;
  logic [b2da_pkg::CHAR_W-1:0] char_pos1;
  logic [b2da_pkg::CHAR_W-1:0] char_pos2;
  logic [b2da_pkg::CHAR_W-1:0] char_pos3;
  logic [b2da_pkg::CHAR_W-1:0] char_pos4;

  modport source (output valid, output char_pos0, output char_pos1, output char_pos2,
                  output char_pos3, output char_pos4, input ready);
  modport sink   (input valid, input char_pos0, input char_pos1, input char_pos2,
                  input char_pos3, input char_pos4, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/binary_to_decimal_ascii.sv -----
// Top level: three-stage pipeline turning a 16-bit value into five left-justified ASCII characters.
`default_nettype none

// Converts an unsigned 16-bit number into its decimal text, five six-bit ASCII
// characters, most significant first. Leading zeros go (zero shows as a single
// '0') and the freed places on the right hold spaces. One item enters per
// clock unless all stages are full and out_ch.ready is low. Two double dabble
// stages of eight bits each feed one stage that strips zeros and maps to ASCII,
// whose register is the output register. Backpressure from out_ch.ready ripples
// back through the stage valid bits, so an empty stage always takes an item
// and a full pipeline with a stalled output holds all three items intact.
module binary_to_decimal_ascii (
  input  wire clk,
  input  wire rst_n,
  b2da_in_if.sink    in_ch,
  b2da_out_if.source out_ch
);
  import b2da_pkg::*;

  // stage flow control
  stage_ctl_t s1_ctl, s2_ctl, s3_ctl;
  logic v1_r, v2_r, v3_r;
  logic v1_nxt, v2_nxt, v3_nxt;

  // stage payloads
  bcd_t  s1_bcd_r;
  half_t s1_low_r;
  bcd_t  s2_bcd_r;
  char_t s3_chars_r [DIGITS];

  // combinational results feeding each stage
  bcd_t  hi_bcd, full_bcd;
  char_t fmt_chars [DIGITS];

  // A stage loads when it is empty or its contents move on this cycle.
  always_comb begin
    s3_ctl.valid  = v3_r;
    s3_ctl.enable = !v3_r || out_ch.ready;
    s2_ctl.valid  = v2_r;
    s2_ctl.enable = !v2_r || s3_ctl.enable;
    s1_ctl.valid  = v1_r;
    s1_ctl.enable = !v1_r || s2_ctl.enable;
  end

  assign in_ch.ready = s1_ctl.enable;

  // Valid bits advance with the data; hold when the stage is held.
  always_comb begin
    v1_nxt = s1_ctl.enable ? in_ch.valid : v1_r;
    v2_nxt = s2_ctl.enable ? s1_ctl.valid : v2_r;
    v3_nxt = s3_ctl.enable ? s2_ctl.valid : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // Stage 1: shift in the high byte
  b2da_dabble u_dabble_hi (
    .bcd_i  ('0),
    .bits_i (in_ch.number_in[NUM_W-1:HALF_W]),
    .bcd_o  (hi_bcd)
  );

  // Stage 2: shift in the low byte
  b2da_dabble u_dabble_lo (
    .bcd_i  (s1_bcd_r),
    .bits_i (s1_low_r),
    .bcd_o  (full_bcd)
  );

  // Stage 3: drop leading zeros and map to characters
  b2da_format u_format (
    .bcd_i   (s2_bcd_r),
    .chars_o (fmt_chars)
  );

  always_ff @(posedge clk) begin
    if (s1_ctl.enable) begin
      s1_bcd_r <= hi_bcd;
      s1_low_r <= in_ch.number_in[HALF_W-1:0];
    end
    if (s2_ctl.enable) begin
      s2_bcd_r <= full_bcd;
    end
    if (s3_ctl.enable) begin
      s3_chars_r <= fmt_chars;
    end
  end

  assign out_ch.valid     = s3_ctl.valid;
  assign out_ch.char_pos0 = s3_chars_r[0];
  assign out_ch.char_pos1 = s3_chars_r[1];
  assign out_ch.char_pos2 = s3_chars_r[2];
  assign out_ch.char_pos3 = s3_chars_r[3];
  assign out_ch.char_pos4 = s3_chars_r[4];

  // Input is only refused when every stage holds an item.
  a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (v1_r && v2_r && v3_r))
    else $error("input refused while a pipeline stage is empty");

  // An accepted item lands in stage 1.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v1_r)
    else $error("accepted item lost from stage 1");

  // The leftmost character is always a digit.
  a_first_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.char_pos0 != ASCII_SPACE))
    else $error("leftmost character is padding");

  // Padding is contiguous on the right.
  a_pad_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.char_pos1 == ASCII_SPACE) |->
      (out_ch.char_pos2 == ASCII_SPACE && out_ch.char_pos3 == ASCII_SPACE &&
       out_ch.char_pos4 == ASCII_SPACE))
    else $error("digit after padding");

endmodule

`default_nettype wire

// ----- hw/rtl/b2da_dabble.sv -----
// Eight double dabble steps: shift eight binary bits into a BCD accumulator.
`default_nettype none

module b2da_dabble (
  input  wire b2da_pkg::bcd_t  bcd_i,
  input  wire b2da_pkg::half_t bits_i,
  output b2da_pkg::bcd_t       bcd_o
);
  import b2da_pkg::*;

  bcd_t acc;

  always_comb begin
    acc = bcd_i;
    for (int i = 0; i < HALF_W; i++) begin
      // correct every digit that would pass nine after doubling
      for (int d = 0; d < DIGITS; d++) begin
        if (acc[d*DIGIT_W +: DIGIT_W] >= DABBLE_LIMIT) begin
          acc[d*DIGIT_W +: DIGIT_W] = acc[d*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
        end
      end
      acc = {acc[BCD_W-2:0], bits_i[HALF_W-1-i]};
    end
  end

  assign bcd_o = acc;

endmodule

`default_nettype wire

// ----- hw/rtl/b2da_format.sv -----
// Leading zero removal and ASCII mapping of five BCD digits, left-justified.
`default_nettype none

module b2da_format (
  input  wire b2da_pkg::bcd_t  bcd_i,
  output b2da_pkg::char_t      chars_o [b2da_pkg::DIGITS]
);
  import b2da_pkg::*;

  lead_t  lead;
  bcd_t   shifted;
  logic [LEAD_W:0] src;

  // count leading zero digits; the last digit always stays
  always_comb begin
    priority if (bcd_i[4*DIGIT_W +: DIGIT_W] != '0) begin
      lead = 3'd0;
    end else if (bcd_i[3*DIGIT_W +: DIGIT_W] != '0) begin
      lead = 3'd1;
    end else if (bcd_i[2*DIGIT_W +: DIGIT_W] != '0) begin
      lead = 3'd2;
    end else if (bcd_i[1*DIGIT_W +: DIGIT_W] != '0) begin
      lead = 3'd3;
    end else begin
      lead = 3'd4;
    end
  end

  assign shifted = bcd_i << {lead, 2'b00};

  always_comb begin
    src = '0;
    for (int k = 0; k < DIGITS; k++) begin
      src = (LEAD_W+1)'(k) + {1'b0, lead};
      if (src < (LEAD_W+1)'(DIGITS)) begin
        chars_o[k] = ASCII_ZERO + {2'b00, shifted[(DIGITS-1-k)*DIGIT_W +: DIGIT_W]};
      end else begin
        chars_o[k] = ASCII_SPACE;
      end
    end
  end

endmodule

`default_nettype wire

// ----- bench/binary_to_decimal_ascii_test.sv -----
// Self-checking bench for the binary to decimal text converter: corner values, then random streams.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_test;
  import b2da_pkg::*;

  // Five characters, index 0 is the leftmost position.
  typedef logic [DIGITS-1:0][CHAR_W-1:0] text_t;

  // Keeps the texts still owed by the converter, oldest first, and checks each
  // result against the head of the queue.
  class text_scoreboard;
    text_t awaited[$];
    int    failures;

    function new();
      failures = 0;
    endfunction

    // Decimal text of a value: split into five digits, drop up to four
    // leading zeros and pad the right with spaces.
    function text_t decimal_text(num_t value);
      int unsigned rest;
      int unsigned digit [DIGITS];
      int          lead;
      text_t       text;
      rest = value;
      for (int k = DIGITS - 1; k >= 0; k--) begin
        digit[k] = rest % 10;
        rest     = rest / 10;
      end
      lead = 0;
      while (lead < DIGITS - 1 && digit[lead] == 0) lead++;
      for (int k = 0; k < DIGITS; k++) begin
        if (k + lead < DIGITS) begin
          text[k] = ASCII_ZERO + char_t'(digit[k + lead]);
        end else begin
          text[k] = ASCII_SPACE;
        end
      end
      return text;
    endfunction

    function void note_value(num_t value);
      awaited.push_back(decimal_text(value));
    endfunction

    function void check_text(text_t got);
      text_t want;
      if (awaited.size() == 0) begin
        $error("result %h arrived with nothing awaited", got);
        failures++;
        return;
      end
      want = awaited.pop_front();
      for (int k = 0; k < DIGITS; k++) begin
        if (got[k] !== want[k]) begin
          $error("char_pos%0d: expected %0d, got %0d", k, want[k], got[k]);
          failures++;
        end
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 190;
  localparam int LONG_HOLD    = 80;
  localparam int CORNER_COUNT = 22;

  logic clk;
  logic rst_n;

  b2da_in_if  in_if ();
  b2da_out_if out_if ();

  binary_to_decimal_ascii DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  text_scoreboard board;

  // Idle percentages for the current phase; read by the sender task and the
  // receiver process.
  int send_idle_pct;
  int sink_stall_pct;

  // Long receiver hold-offs: the main sequence raises the request count, the
  // receiver serves it and counts the hold down itself.
  int holds_asked;

  // Extremes, every digit count, inner zeros and both alternating bit patterns.
  num_t corner_values [CORNER_COUNT] = '{
    16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd909, 16'd999,
    16'd1000, 16'd1010, 16'd9999, 16'd10000, 16'd10001, 16'd20005,
    16'd12345, 16'd32768, 16'd54321, 16'h5555, 16'hAAAA, 16'd60000,
    16'd65534, 16'd65535
  };

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Draw a value, spreading the draws over every digit count so that each
  // amount of zero stripping turns up often.
  function automatic num_t pick_value();
    case ($urandom_range(0, 5))
      0:       return num_t'($urandom_range(0, 9));
      1:       return num_t'($urandom_range(10, 99));
      2:       return num_t'($urandom_range(100, 999));
      3:       return num_t'($urandom_range(1000, 9999));
      4:       return num_t'($urandom_range(10000, 65535));
      default: return num_t'($urandom);
    endcase
  endfunction

  // Offer one value after a random gap and hold it until the converter takes it.
  // Valid stays high on exit so that back-to-back items need no second update.
  task automatic put_value(input num_t value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.number_in <= value;
    do @(posedge clk); while (!in_if.ready);
    board.note_value(value);
  endtask

  // Receiver: check what is accepted at this edge, then decide on ready for
  // the next one. A pending hold request drops ready for a long stretch.
  initial begin
    int stall_left;
    int holds_done;
    stall_left   = 0;
    holds_done   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        board.check_text({out_if.char_pos4, out_if.char_pos3, out_if.char_pos2,
                          out_if.char_pos1, out_if.char_pos0});
      end
      if (holds_done != holds_asked) begin
        stall_left = LONG_HOLD;
        holds_done++;
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  // Watchdog: end the run if the traffic never drains.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // Main sequence: reset, corner values, then five random phases that vary
  // the idling on each side.
  initial begin
    int sender_idle [5];
    int sink_idle [5];
    sender_idle = '{0, 74, 0, 22, 0};
    sink_idle   = '{0, 0, 74, 22, 0};

    board           = new();
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.number_in = '0;
    send_idle_pct   = 0;
    sink_stall_pct  = 0;
    holds_asked     = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corner values, back to back with a ready receiver.
    foreach (corner_values[i]) put_value(corner_values[i]);

    for (int p = 0; p < 5; p++) begin
      send_idle_pct  <= sender_idle[p];
      sink_stall_pct <= sink_idle[p];
      // First phase: hold the receiver off while the sender streams without
      // gaps, so the pipeline fills and pushes back on its input.
      if (p == 0) holds_asked <= holds_asked + 1;
      repeat (PHASE_ITEMS) put_value(pick_value());
    end
    in_if.valid <= 1'b0;

    // Drain, then keep watching for anything unexpected.
    while (board.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    if (board.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
